>>> rtl/satvt_pkg.sv
// Shared types and constants of the satellite view table.
`timescale 1ns / 1ps
package satvt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int USED_DEPTH  = 32;
    localparam int SYSTEMS     = 6;

    localparam int TAB_AW  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int USED_AW = $clog2(USED_DEPTH);
    localparam int USED_CW = $clog2(USED_DEPTH + 1);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int SYS_W  = 3;
    localparam int MSG_W  = 4;
    localparam int PRN_W  = 10;
    localparam int EL_W   = 8;
    localparam int AZ_W   = 10;
    localparam int SNR_W  = 8;
    localparam int OCNT_W = 7;

    localparam logic [OCNT_W-1:0] OCNT_MAX = '1;
    localparam logic [MSG_W-1:0]  MSG_FIRST = MSG_W'(1);

    typedef enum logic [1:0] {
        MODE_EPOCH  = 2'd0,
        MODE_RECORD = 2'd1,
        MODE_USED   = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_ANSWERED  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PURGE,
        S_CHECK,
        S_SEARCH,
        S_QUERY,
        S_DONE
    } t_bstate;

    // Classified item as it travels from the front to the back.
    typedef struct packed {
        t_mode                    mode;
        logic [SYS_W-1:0]         sys;
        logic [PRN_W-1:0]         prn;
        logic signed [EL_W-1:0]   el;
        logic signed [AZ_W-1:0]   az;
        logic signed [SNR_W-1:0]  snr;
        logic                     known;
        logic                     msg_first;
        logic                     prn_zero;
    } t_item;

    // One table entry.
    typedef struct packed {
        logic [SYS_W-1:0]         sys;
        logic [PRN_W-1:0]         prn;
        logic signed [EL_W-1:0]   el;
        logic signed [AZ_W-1:0]   az;
        logic signed [SNR_W-1:0]  snr;
    } t_entry;

endpackage

>>> rtl/satvt_front.sv
// Input side: accept beats, classify them and queue them for the back end.
`timescale 1ns / 1ps
module satvt_front
    import satvt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_mode,
    input  logic [SYS_W-1:0]        i_constellation,
    input  logic [MSG_W-1:0]        i_msg_num,
    input  logic [PRN_W-1:0]        i_prn,
    input  logic signed [EL_W-1:0]  i_elevation,
    input  logic signed [AZ_W-1:0]  i_azimuth,
    input  logic signed [SNR_W-1:0] i_snr,
    output logic                    o_q_valid,
    output t_item                   o_q_item,
    input  logic                    i_q_take
);

    t_item          r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           push, pop;
    t_item          cls;

    always_comb begin
        cls.mode      = t_mode'(i_mode);
        cls.sys       = i_constellation;
        cls.prn       = i_prn;
        cls.el        = i_elevation;
        cls.az        = i_azimuth;
        cls.snr       = i_snr;
        cls.known     = (32'(i_constellation) < SYSTEMS);
        cls.msg_first = (i_msg_num == MSG_FIRST);
        cls.prn_zero  = (i_prn == '0);
    end

    assign o_stall   = (r_cnt == QCW'(QDEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_take && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + QAW'(1);
            if (pop)  r_rp <= r_rp + QAW'(1);
            r_cnt <= r_cnt + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
    end

endmodule

>>> rtl/satvt_back.sv
// Back end: sequencer over the satellite table, used-PRN set and result register.
`timescale 1ns / 1ps
module satvt_back
    import satvt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_take,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [OCNT_W-1:0]   o_view_count,
    output logic [OCNT_W-1:0]   o_used_count
);

    t_bstate             r_state, n_state;
    t_item               r_item, n_item;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [USED_CW-1:0]  r_used_total, n_used_total;
    logic [SYSTEMS-1:0]  r_flags, n_flags;
    logic [CNT_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_wr, n_wr;
    logic                r_pend, n_pend;
    logic [TAB_AW-1:0]   r_idx, n_idx;
    logic [OCNT_W-1:0]   r_view, n_view;
    logic [OCNT_W-1:0]   r_usedc, n_usedc;
    t_status             r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [OCNT_W-1:0]   r_out_view, n_out_view;
    logic [OCNT_W-1:0]   r_out_used, n_out_used;

    t_entry              mem [TABLE_DEPTH];
    t_entry              r_rdata;
    logic                mem_we;
    logic [TAB_AW-1:0]   mem_wa;
    t_entry              mem_wd;

    logic [PRN_W-1:0]    r_used [USED_DEPTH];
    logic                used_we;

    logic [USED_DEPTH-1:0] dup_vec, qry_vec;
    logic [SYSTEMS-1:0]    sys_onehot;
    logic                  dup_hit, qry_hit, flag_hit;
    logic                  take, out_free, rd_more, scan_end, sel_sys, hit_match;
    logic                  tab_full, used_full;
    t_entry                upd_entry, new_entry;

    // Parallel membership test against the used set.
    always_comb begin
        for (int j = 0; j < USED_DEPTH; j++) begin
            dup_vec[j] = (USED_CW'(j) < r_used_total) && (r_used[j] == r_item.prn);
            qry_vec[j] = (USED_CW'(j) < r_used_total) && (r_used[j] == r_rdata.prn);
        end
        for (int s = 0; s < SYSTEMS; s++) begin
            sys_onehot[s] = (r_item.sys == SYS_W'(s));
        end
    end

    assign dup_hit   = |dup_vec;
    assign qry_hit   = |qry_vec;
    assign flag_hit  = |(r_flags & sys_onehot);
    assign take      = (r_state == S_IDLE) && i_q_valid;
    assign o_q_take  = take;
    assign out_free  = !r_out_valid || !i_stall;
    assign rd_more   = (r_rd < r_count);
    assign scan_end  = !r_pend && !rd_more;
    assign sel_sys   = (r_rdata.sys == r_item.sys);
    assign hit_match = r_pend && sel_sys && (r_rdata.prn == r_item.prn);
    assign tab_full  = (r_count >= CNT_W'(TABLE_DEPTH));
    assign used_full = (r_used_total >= USED_CW'(USED_DEPTH));

    always_comb begin
        upd_entry = r_rdata;
        if (r_item.snr > r_rdata.snr) upd_entry.snr = r_item.snr;
        if (r_item.el >= 0)           upd_entry.el  = r_item.el;
        if (r_item.az >= 0)           upd_entry.az  = r_item.az;
        new_entry.sys = r_item.sys;
        new_entry.prn = r_item.prn;
        new_entry.el  = r_item.el;
        new_entry.az  = r_item.az;
        new_entry.snr = r_item.snr;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (r_item.mode)
                    MODE_RECORD: begin
                        if (!r_item.known)                       n_state = S_DONE;
                        else if (r_item.msg_first && !flag_hit) n_state = S_PURGE;
                        else                                     n_state = S_CHECK;
                    end
                    MODE_QUERY: begin
                        n_state = r_item.known ? S_QUERY : S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_PURGE: begin
                if (scan_end) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = (r_item.prn_zero || tab_full) ? S_DONE : S_SEARCH;
            end
            S_SEARCH: begin
                if (hit_match || scan_end) n_state = S_DONE;
            end
            S_QUERY: begin
                if (scan_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_item       = r_item;
        n_count      = r_count;
        n_used_total = r_used_total;
        n_flags      = r_flags;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_pend       = r_pend;
        n_idx        = r_idx;
        n_view       = r_view;
        n_usedc      = r_usedc;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_view   = r_out_view;
        n_out_used   = r_out_used;
        mem_we       = 1'b0;
        mem_wa       = r_idx;
        mem_wd       = r_rdata;
        used_we      = 1'b0;

        if (r_out_valid && !i_stall) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take) n_item = i_q_item;
            end
            S_DISPATCH: begin
                n_rd     = '0;
                n_wr     = '0;
                n_pend   = 1'b0;
                n_view   = '0;
                n_usedc  = '0;
                n_status = ST_IGNORED;
                case (r_item.mode)
                    MODE_EPOCH: begin
                        n_used_total = '0;
                        n_flags      = '0;
                        n_status     = ST_UPDATED;
                    end
                    MODE_USED: begin
                        if (r_item.prn_zero)  n_status = ST_IGNORED;
                        else if (used_full)   n_status = ST_FULL;
                        else if (dup_hit)     n_status = ST_DUPLICATE;
                        else begin
                            used_we      = 1'b1;
                            n_used_total = r_used_total + USED_CW'(1);
                            n_status     = ST_INSERTED;
                        end
                    end
                    default: n_status = ST_IGNORED;
                endcase
            end
            S_PURGE: begin
                // Compact in place: keep entries of other constellations.
                if (rd_more) n_rd = r_rd + CNT_W'(1);
                n_pend = rd_more;
                if (r_pend && !sel_sys) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr[TAB_AW-1:0];
                    mem_wd = r_rdata;
                    n_wr   = r_wr + CNT_W'(1);
                end
                if (scan_end) begin
                    n_count = r_wr;
                    n_flags = r_flags | sys_onehot;
                end
            end
            S_CHECK: begin
                n_rd     = '0;
                n_pend   = 1'b0;
                n_status = r_item.prn_zero ? ST_IGNORED : ST_FULL;
            end
            S_SEARCH: begin
                if (rd_more) begin
                    n_rd  = r_rd + CNT_W'(1);
                    n_idx = r_rd[TAB_AW-1:0];
                end
                n_pend = rd_more;
                if (hit_match) begin
                    mem_we   = 1'b1;
                    mem_wa   = r_idx;
                    mem_wd   = upd_entry;
                    n_status = ST_UPDATED;
                end else if (scan_end) begin
                    mem_we   = 1'b1;
                    mem_wa   = r_count[TAB_AW-1:0];
                    mem_wd   = new_entry;
                    n_count  = r_count + CNT_W'(1);
                    n_status = ST_INSERTED;
                end
            end
            S_QUERY: begin
                if (rd_more) n_rd = r_rd + CNT_W'(1);
                n_pend = rd_more;
                if (r_pend && sel_sys) begin
                    if (r_view != OCNT_MAX) n_view = r_view + OCNT_W'(1);
                    if (qry_hit && r_usedc != OCNT_MAX) n_usedc = r_usedc + OCNT_W'(1);
                end
                if (scan_end) n_status = ST_ANSWERED;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_view   = r_view;
                    n_out_used   = r_usedc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_used_total <= '0;
            r_flags      <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_used_total <= n_used_total;
            r_flags      <= n_flags;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_rd         <= n_rd;
        r_wr         <= n_wr;
        r_idx        <= n_idx;
        r_view       <= n_view;
        r_usedc      <= n_usedc;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_view   <= n_out_view;
        r_out_used   <= n_out_used;
    end

    // Table memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[r_rd[TAB_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (used_we) r_used[r_used_total[USED_AW-1:0]] <= r_item.prn;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_view_count = r_out_view;
    assign o_used_count = r_out_used;

endmodule

>>> rtl/satellite_view_table.sv
// Top level of the satellite view table: front queue, back sequencer, checks.
`timescale 1ns / 1ps
// Keeps up to 64 satellites in view, keyed by constellation and PRN, plus a
// duplicate-free set of up to 32 PRNs in use. Each input beat gives exactly
// one result beat, in order. The front takes beats into a two-entry queue and
// classifies them; the back runs one item at a time over the table memory,
// which has one read and one write port, so the table scans set the time:
// epoch and used-PRN items need no scan, a count query scans the table once,
// a satellite record scans it once when it searches for its entry and twice
// when it also purges its constellation first (a scan walks the filled
// entries, at most 64). The result register frees the back end as soon as a
// result is taken, and the queue keeps accepting while a result waits.
// Reset is synchronous and clears counts, flags and handshake state; table
// and used-set contents need no clearing since only filled entries are read.
module satellite_view_table
    import satvt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_mode,
    input  logic [SYS_W-1:0]        i_constellation,
    input  logic [MSG_W-1:0]        i_msg_num,
    input  logic [PRN_W-1:0]        i_prn,
    input  logic signed [EL_W-1:0]  i_elevation,
    input  logic signed [AZ_W-1:0]  i_azimuth,
    input  logic signed [SNR_W-1:0] i_snr,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_status,
    output logic [OCNT_W-1:0]       o_view_count,
    output logic [OCNT_W-1:0]       o_used_count
);

    logic  q_valid;
    t_item q_item;
    logic  q_take;

    // Front: accept and classify beats, hold them in the queue.
    satvt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_constellation (i_constellation),
        .i_msg_num       (i_msg_num),
        .i_prn           (i_prn),
        .i_elevation     (i_elevation),
        .i_azimuth       (i_azimuth),
        .i_snr           (i_snr),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_take        (q_take)
    );

    // Back: walk the table, update state, drive the result register.
    satvt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_take     (q_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_view_count (o_view_count),
        .o_used_count (o_used_count)
    );

    // Only an answered query carries counts.
    a_counts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_ANSWERED) |-> (o_view_count == '0 && o_used_count == '0))
        else $error("counts set on a non-query result");

    // In-use entries are a subset of in-view entries.
    a_used_le_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_used_count <= o_view_count))
        else $error("used count above view count");

    // A query never reports more entries than the table holds.
    a_view_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ANSWERED) |-> (32'(o_view_count) <= TABLE_DEPTH))
        else $error("view count above table depth");

endmodule

>>> dv/satellite_view_table_tb.sv
// Self-checking testbench for the satellite view table.
`timescale 1ns / 1ps
module satellite_view_table_tb;
    import satvt_pkg::*;

    localparam string PASS_MSG = "== PASS ==";
    localparam string FAIL_MSG = "== FAIL ==";
    localparam int    CYCLE_LIMIT = 2000000;

    typedef struct {
        t_mode                   mode;
        logic [SYS_W-1:0]        sys;
        logic [MSG_W-1:0]        msg;
        logic [PRN_W-1:0]        prn;
        logic signed [EL_W-1:0]  el;
        logic signed [AZ_W-1:0]  az;
        logic signed [SNR_W-1:0] snr;
    } t_beat;

    typedef struct {
        t_status           status;
        logic [OCNT_W-1:0] view;
        logic [OCNT_W-1:0] used;
    } t_answer;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] in_mode = '0;
    logic [SYS_W-1:0] in_sys = '0;
    logic [MSG_W-1:0] in_msg = '0;
    logic [PRN_W-1:0] in_prn = '0;
    logic signed [EL_W-1:0] in_el = '0;
    logic signed [AZ_W-1:0] in_az = '0;
    logic signed [SNR_W-1:0] in_snr = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] out_status;
    logic [OCNT_W-1:0] out_view, out_used;

    satellite_view_table DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_mode(in_mode), .i_constellation(in_sys), .i_msg_num(in_msg),
        .i_prn(in_prn), .i_elevation(in_el), .i_azimuth(in_az), .i_snr(in_snr),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(out_status), .o_view_count(out_view), .o_used_count(out_used)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Shadow copy of the table and the used set.
    logic [PRN_W-1:0]        tbl_prn [TABLE_DEPTH];
    logic signed [EL_W-1:0]  tbl_el  [TABLE_DEPTH];
    logic signed [AZ_W-1:0]  tbl_az  [TABLE_DEPTH];
    logic signed [SNR_W-1:0] tbl_snr [TABLE_DEPTH];
    logic [SYS_W-1:0]        tbl_sys [TABLE_DEPTH];
    int                      tbl_count = 0;
    logic [PRN_W-1:0]        inuse_prn [USED_DEPTH];
    int                      used_num = 0;
    logic [SYSTEMS-1:0]      cleared = '0;

    t_beat   pending_beats[$];
    t_answer expected_answers[$];
    int      fail_count = 0;
    bit      stim_done = 1'b0;

    function automatic bit prn_used(logic [PRN_W-1:0] p);
        for (int j = 0; j < used_num; j++)
            if (inuse_prn[j] == p) return 1'b1;
        return 1'b0;
    endfunction

    // Remove one constellation, keeping the order of the others.
    function automatic void purge_sys(logic [SYS_W-1:0] s);
        int w;
        w = 0;
        for (int r = 0; r < tbl_count; r++) begin
            if (tbl_sys[r] != s) begin
                tbl_prn[w] = tbl_prn[r]; tbl_el[w] = tbl_el[r];
                tbl_az[w] = tbl_az[r]; tbl_snr[w] = tbl_snr[r];
                tbl_sys[w] = tbl_sys[r];
                w++;
            end
        end
        tbl_count = w;
    endfunction

    function automatic t_answer apply_record(t_beat b);
        t_answer a;
        a = '{ST_IGNORED, '0, '0};
        if (b.sys >= SYSTEMS) return a;
        if (b.msg == MSG_FIRST && !cleared[b.sys]) begin
            purge_sys(b.sys);
            cleared[b.sys] = 1'b1;
        end
        if (b.prn == 0) return a;
        if (tbl_count >= TABLE_DEPTH) begin
            a.status = ST_FULL;
            return a;
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_prn[i] == b.prn && tbl_sys[i] == b.sys) begin
                if (b.snr > tbl_snr[i]) tbl_snr[i] = b.snr;
                if (b.el >= 0) tbl_el[i] = b.el;
                if (b.az >= 0) tbl_az[i] = b.az;
                a.status = ST_UPDATED;
                return a;
            end
        end
        tbl_prn[tbl_count] = b.prn; tbl_el[tbl_count] = b.el;
        tbl_az[tbl_count] = b.az; tbl_snr[tbl_count] = b.snr;
        tbl_sys[tbl_count] = b.sys;
        tbl_count++;
        a.status = ST_INSERTED;
        return a;
    endfunction

    function automatic t_answer predict_answer(t_beat b);
        t_answer a;
        int nv, nu;
        a = '{ST_IGNORED, '0, '0};
        nv = 0;
        nu = 0;
        case (b.mode)
            MODE_EPOCH: begin
                used_num = 0;
                cleared = '0;
                a.status = ST_UPDATED;
            end
            MODE_RECORD: a = apply_record(b);
            MODE_USED: begin
                if (b.prn == 0) a.status = ST_IGNORED;
                else if (used_num >= USED_DEPTH) a.status = ST_FULL;
                else if (prn_used(b.prn)) a.status = ST_DUPLICATE;
                else begin
                    inuse_prn[used_num] = b.prn;
                    used_num++;
                    a.status = ST_INSERTED;
                end
            end
            default: begin
                if (b.sys < SYSTEMS) begin
                    for (int i = 0; i < tbl_count; i++) begin
                        if (tbl_sys[i] == b.sys) begin
                            nv++;
                            if (prn_used(tbl_prn[i])) nu++;
                        end
                    end
                    a.view = (nv > 127) ? OCNT_MAX : OCNT_W'(nv);
                    a.used = (nu > 127) ? OCNT_MAX : OCNT_W'(nu);
                    a.status = ST_ANSWERED;
                end
            end
        endcase
        return a;
    endfunction

    function automatic t_beat mk(t_mode m, int s, int g, int p, int e, int z, int n);
        t_beat b;
        b.mode = m; b.sys = SYS_W'(s); b.msg = MSG_W'(g); b.prn = PRN_W'(p);
        b.el = EL_W'(e); b.az = AZ_W'(z); b.snr = SNR_W'(n);
        return b;
    endfunction

    // Random beat: mostly well-formed records with small PRN pools so updates hit.
    function automatic t_beat rand_beat();
        t_beat b;
        int k;
        k = $urandom_range(99);
        b = mk(MODE_RECORD, $urandom_range(SYSTEMS - 1), $urandom_range(1, 4),
               $urandom_range(1, 24), $urandom_range(0, 90), $urandom_range(0, 359),
               $urandom_range(0, 60));
        if (k < 4) b.mode = MODE_EPOCH;
        else if (k < 22) b.mode = MODE_USED;
        else if (k < 34) b.mode = MODE_QUERY;
        if (k >= 90) begin
            // noise across the full field ranges
            b.sys = SYS_W'($urandom); b.msg = MSG_W'($urandom);
            b.prn = PRN_W'($urandom);
            b.el = EL_W'($urandom); b.az = AZ_W'($urandom); b.snr = SNR_W'($urandom);
            if ($urandom_range(1)) b.prn = '0;
        end
        if ($urandom_range(9) == 0) b.el = EL_W'(-1);
        if ($urandom_range(9) == 0) b.az = AZ_W'(-1);
        if ($urandom_range(9) == 0) b.snr = SNR_W'(-1);
        return b;
    endfunction

    initial begin
        // Directed: all modes, field extremes, unknown systems, zero PRN.
        pending_beats.push_back(mk(MODE_QUERY, 7, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_RECORD, 6, 1, 5, 10, 10, 10));
        pending_beats.push_back(mk(MODE_RECORD, 0, 1, 1023, -1, -1, -1));
        pending_beats.push_back(mk(MODE_RECORD, 0, 2, 1023, 127, 511, 127));
        pending_beats.push_back(mk(MODE_RECORD, 0, 3, 1023, -1, -1, -128));
        pending_beats.push_back(mk(MODE_RECORD, 5, 15, 7, -128, -512, 0));
        pending_beats.push_back(mk(MODE_RECORD, 0, 1, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_RECORD, 5, 1, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_USED, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_USED, 0, 0, 7, 0, 0, 0));
        pending_beats.push_back(mk(MODE_USED, 0, 0, 7, 0, 0, 0));
        pending_beats.push_back(mk(MODE_USED, 0, 0, 1023, 0, 0, 0));
        pending_beats.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_QUERY, 5, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_EPOCH, 7, 15, 1023, -1, -1, -1));
        pending_beats.push_back(mk(MODE_QUERY, 5, 0, 0, 0, 0, 0));
        // Fill the used set to overflow, then fill the table to overflow.
        for (int i = 1; i <= USED_DEPTH + 1; i++)
            pending_beats.push_back(mk(MODE_USED, 0, 0, i, 0, 0, 0));
        pending_beats.push_back(mk(MODE_USED, 0, 0, 1, 0, 0, 0));
        for (int i = 1; i <= TABLE_DEPTH + 1; i++)
            pending_beats.push_back(mk(MODE_RECORD, 1, 2, i, 5, 5, 5));
        pending_beats.push_back(mk(MODE_RECORD, 1, 2, 3, 9, 9, 9));
        pending_beats.push_back(mk(MODE_QUERY, 1, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_RECORD, 1, 1, 3, 9, 9, 9));
        pending_beats.push_back(mk(MODE_QUERY, 1, 0, 0, 0, 0, 0));
        for (int i = 0; i < 780; i++) pending_beats.push_back(rand_beat());
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Set at the rising edge when the input beat is taken.
    bit took_beat = 1'b0;

    // Driver: bursts and gaps; also one pause until every answer is in.
    int burst_left = 0, gap_left = 0, sent = 0;
    bit drained_once = 1'b0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || took_beat) begin
                if (sent == 300 && !drained_once && expected_answers.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() == 0) begin
                    in_valid <= 1'b0;
                    stim_done = 1'b1;
                end else begin
                    t_beat b;
                    if (sent == 300) drained_once = 1'b1;
                    b = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    in_mode <= b.mode; in_sys <= b.sys; in_msg <= b.msg;
                    in_prn <= b.prn; in_el <= b.el; in_az <= b.az; in_snr <= b.snr;
                    sent++;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(20);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(60);
                    end
                end
            end
        end
    end

    // Acceptance and prediction at the rising edge.
    always @(posedge clk) begin
        t_beat b;
        took_beat = rst_n && in_valid && !in_stall;
        if (took_beat) begin
            b.mode = t_mode'(in_mode); b.sys = in_sys; b.msg = in_msg; b.prn = in_prn;
            b.el = in_el; b.az = in_az; b.snr = in_snr;
            expected_answers.push_back(predict_answer(b));
        end
    end

    // Receiver stall pattern with one long hold-off.
    int stall_cycles = 0;
    always @(negedge clk) begin
        stall_cycles++;
        if (stall_cycles >= 3000 && stall_cycles < 6000) out_stall <= 1'b1;
        else if (stall_cycles % 200 < 100) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(3) == 0);
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk) begin
        t_answer e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_answers.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                e = expected_answers.pop_front();
                if (out_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, out_status);
                    fail_count++;
                end
                if (out_view !== e.view) begin
                    $error("view_count expected %0d actual %0d", e.view, out_view);
                    fail_count++;
                end
                if (out_used !== e.used) begin
                    $error("used_count expected %0d actual %0d", e.used, out_used);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        while (!(stim_done && !in_valid && expected_answers.size() == 0)
               && cyc < CYCLE_LIMIT) begin
            @(posedge clk);
            cyc++;
        end
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout");
            $display(FAIL_MSG);
            $finish;
        end else begin
            repeat (200) @(posedge clk);
            if (fail_count == 0 && expected_answers.size() == 0) $display(PASS_MSG);
            else $display(FAIL_MSG);
            $finish;
        end
    end
endmodule
